// File: hdl/srarq_pkg.sv
`default_nettype none

package srarq_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_WINDOW = 8;
  localparam int DEF_SEQ_WIDTH  = 4;

  // fixed field widths
  localparam int CFG_W     = 3;
  localparam int MASK_W    = 8;
  localparam int SLOT_W    = 3;
  localparam int SEQ_NUM_W = 4;
  localparam int OUTCOME_W = 3;

  // sequence number width loaded by reset
  localparam int RESET_SEQ_BITS = 3;

  // command codes
  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_ROUND   = 1'b1;

  // outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_NEW_ACKED    = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_NEW_ACK_LOST = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_DUP_ACKED    = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_DUP_ACK_LOST = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_DAMAGED_NAK  = 3'd4;
  localparam logic [OUTCOME_W-1:0] OUT_LOST         = 3'd5;
  localparam logic [OUTCOME_W-1:0] OUT_RESTARTED    = 3'd6;

  typedef struct packed {
    logic              func;
    logic [MASK_W-1:0] frame_arrived_mask;
    logic [MASK_W-1:0] frame_damaged_mask;
    logic [MASK_W-1:0] ack_arrived_mask;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [SEQ_NUM_W-1:0] seq_number;
    logic [OUTCOME_W-1:0] outcome;
    logic                 last;
  } rsp_t;

  // datapath operations selected by the control word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FETCH,
    OP_VISIT,
    OP_SLIDE,
    OP_RESTART
  } uop_t;

  typedef struct packed {
    uop_t op;
  } ctrl_t;

  typedef struct packed {
    logic restart;
    logic in_window;
    logic head_acked;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/srarq_useq.sv
`default_nettype none

module srarq_useq
  import srarq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  req_valid,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_RESTART,
    C_IN_WINDOW,
    C_HEAD_ACKED,
    C_OUT_BUSY
  } cond_t;

  typedef logic [2:0] step_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } uword_t;

  localparam step_t ST_FETCH   = 3'd0;
  localparam step_t ST_DECODE  = 3'd1;
  localparam step_t ST_VISIT   = 3'd2;
  localparam step_t ST_SLIDE   = 3'd3;
  localparam step_t ST_DONE    = 3'd4;
  localparam step_t ST_RESTART = 3'd5;
  localparam step_t ST_RDONE   = 3'd6;

  step_t  upc;
  step_t  upc_next;
  uword_t uw;
  logic   take;

  // control store: jump to target when the condition holds, else fall through
  always_comb begin
    case (upc)
      ST_FETCH:   uw = '{op: OP_FETCH,   cond: C_NO_INPUT,   target: ST_FETCH};
      ST_DECODE:  uw = '{op: OP_NONE,    cond: C_RESTART,    target: ST_RESTART};
      ST_VISIT:   uw = '{op: OP_VISIT,   cond: C_IN_WINDOW,  target: ST_VISIT};
      ST_SLIDE:   uw = '{op: OP_SLIDE,   cond: C_HEAD_ACKED, target: ST_SLIDE};
      ST_DONE:    uw = '{op: OP_NONE,    cond: C_ALWAYS,     target: ST_FETCH};
      ST_RESTART: uw = '{op: OP_RESTART, cond: C_OUT_BUSY,   target: ST_RESTART};
      ST_RDONE:   uw = '{op: OP_NONE,    cond: C_ALWAYS,     target: ST_FETCH};
      default:    uw = '{op: OP_NONE,    cond: C_ALWAYS,     target: ST_FETCH};
    endcase
  end

  always_comb begin
    case (uw.cond)
      C_ALWAYS:     take = 1'b1;
      C_NO_INPUT:   take = !req_valid;
      C_RESTART:    take = stat.restart;
      C_IN_WINDOW:  take = stat.in_window;
      C_HEAD_ACKED: take = stat.head_acked;
      C_OUT_BUSY:   take = stat.out_busy;
      default:      take = 1'b0;
    endcase
    upc_next = take ? uw.target : step_t'(upc + 3'd1);
  end

  assign ctrl.op = uw.op;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

`ifndef SYNTHESIS
  a_fetch_to_decode: assert property (@(posedge clk) disable iff (rst)
    (upc == ST_FETCH && req_valid) |=> upc == ST_DECODE)
    else $error("accepted transfer did not start decode");

  a_slide_exit: assert property (@(posedge clk) disable iff (rst)
    (upc == ST_SLIDE && !stat.head_acked) |=> upc == ST_DONE)
    else $error("slide did not stop at an unacknowledged head");

  a_done_head_open: assert property (@(posedge clk) disable iff (rst)
    (upc == ST_DONE) |-> !stat.head_acked)
    else $error("round ended with an acknowledged head slot");
`endif

endmodule

`default_nettype wire

// File: hdl/srarq_dpath.sv
`default_nettype none

module srarq_dpath
  import srarq_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int SEQ_WIDTH  = DEF_SEQ_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             req_valid,
  input  wire req_t             req,
  input  wire ctrl_t            ctrl,
  output stat_t                 stat,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp
);

  localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SEQ_W       = (SEQ_WIDTH > IDX_W) ? SEQ_WIDTH : IDX_W;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int RST_BITS    = (RESET_SEQ_BITS > SEQ_WIDTH) ? SEQ_WIDTH : RESET_SEQ_BITS;
  localparam int RST_WIN_RAW = 1 << (RST_BITS - 1);
  localparam int RST_WIN     = (RST_WIN_RAW > MAX_WINDOW) ? MAX_WINDOW : RST_WIN_RAW;

  logic [CFG_W-1:0]     seq_bits;
  logic [SEQ_W-1:0]     send_seq     [MAX_WINDOW];
  logic                 slot_acked   [MAX_WINDOW];
  logic [SEQ_W-1:0]     expected_seq [MAX_WINDOW];
  logic [SEQ_WIDTH-1:0] next_send_seq;
  logic [SEQ_WIDTH-1:0] next_recv_seq;
  logic [CNT_W-1:0]     i;
  req_t                 req_q;

  logic [CFG_W-1:0]     eff_bits;
  logic [SEQ_WIDTH-1:0] mod_mask;
  logic [4:0]           win_raw;
  logic [CNT_W-1:0]     win;
  logic [SEQ_WIDTH-1:0] send_m;
  logic [SEQ_WIDTH-1:0] recv_m;
  logic [SEQ_WIDTH-1:0] send_inc;
  logic [SEQ_WIDTH-1:0] recv_inc;
  logic [IDX_W-1:0]     cur;
  logic [SEQ_W-1:0]     cur_seq;
  logic                 cur_acked;
  logic                 arrived;
  logic                 ack_in;
  logic                 hit_any;
  logic [IDX_W-1:0]     hit_idx;
  logic                 more_after;
  logic [OUTCOME_W-1:0] outcome;
  logic                 out_busy;
  logic                 in_window;
  logic                 fetch_acc;
  logic                 do_visit;
  logic                 emit_visit;
  logic                 step_i;
  logic                 do_restart;
  logic                 do_slide;

  // effective width and window size
  always_comb begin
    if (seq_bits == '0) begin
      eff_bits = CFG_W'(1);
    end else if (seq_bits > CFG_W'(SEQ_WIDTH)) begin
      eff_bits = CFG_W'(SEQ_WIDTH);
    end else begin
      eff_bits = seq_bits;
    end
    mod_mask = {SEQ_WIDTH{1'b1}} >> (CFG_W'(SEQ_WIDTH) - eff_bits);
    win_raw  = 5'd1 << (eff_bits - CFG_W'(1));
    win      = (win_raw > 5'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : win_raw[CNT_W-1:0];
  end

  assign send_m   = next_send_seq & mod_mask;
  assign recv_m   = next_recv_seq & mod_mask;
  assign send_inc = SEQ_WIDTH'(send_m + 1'b1) & mod_mask;
  assign recv_inc = SEQ_WIDTH'(recv_m + 1'b1) & mod_mask;

  assign cur       = i[IDX_W-1:0];
  assign in_window = i < win;
  assign cur_seq   = send_seq[cur];
  assign cur_acked = slot_acked[cur];
  assign arrived   = req_q.frame_arrived_mask[cur];
  assign ack_in    = req_q.ack_arrived_mask[cur];

  // receiver list lookup, lowest matching entry wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int j = MAX_WINDOW - 1; j >= 0; j--) begin
      if (CNT_W'(j) < win && expected_seq[j] == cur_seq) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

  // any unacknowledged slot still to come in this round
  always_comb begin
    more_after = 1'b0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      if (CNT_W'(k) > i && CNT_W'(k) < win && !slot_acked[k]) begin
        more_after = 1'b1;
      end
    end
  end

  always_comb begin
    if (arrived) begin
      if (ack_in) begin
        outcome = hit_any ? OUT_NEW_ACKED : OUT_DUP_ACKED;
      end else begin
        outcome = hit_any ? OUT_NEW_ACK_LOST : OUT_DUP_ACK_LOST;
      end
    end else begin
      outcome = req_q.frame_damaged_mask[cur] ? OUT_DAMAGED_NAK : OUT_LOST;
    end
  end

  assign out_busy   = rsp_valid && rsp_stall;
  assign fetch_acc  = (ctrl.op == OP_FETCH) && req_valid;
  assign do_visit   = (ctrl.op == OP_VISIT) && in_window;
  assign emit_visit = do_visit && !cur_acked && !out_busy;
  assign step_i     = do_visit && (cur_acked || !out_busy);
  assign do_restart = (ctrl.op == OP_RESTART) && !out_busy;
  assign do_slide   = (ctrl.op == OP_SLIDE) && slot_acked[0];

  assign stat.restart    = (req_q.func == FUNC_RESTART);
  assign stat.in_window  = in_window;
  assign stat.head_acked = slot_acked[0];
  assign stat.out_busy   = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits      <= CFG_W'(RESET_SEQ_BITS);
      for (int k = 0; k < MAX_WINDOW; k++) begin
        send_seq[k]     <= SEQ_W'(k);
        expected_seq[k] <= SEQ_W'(k);
        slot_acked[k]   <= 1'b0;
      end
      next_send_seq <= SEQ_WIDTH'(RST_WIN);
      next_recv_seq <= SEQ_WIDTH'(RST_WIN);
      i             <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        seq_bits <= cfg_wdata;
      end
      if (fetch_acc) begin
        i <= '0;
      end
      if (step_i) begin
        i <= CNT_W'(i + 1'b1);
      end
      if (emit_visit && arrived) begin
        if (hit_any) begin
          expected_seq[hit_idx] <= SEQ_W'(recv_m);
          next_recv_seq         <= recv_inc;
        end
        if (ack_in) begin
          slot_acked[cur] <= 1'b1;
        end
      end
      if (do_restart) begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
          send_seq[k]     <= SEQ_W'(k);
          expected_seq[k] <= SEQ_W'(k);
          slot_acked[k]   <= 1'b0;
        end
        next_send_seq <= SEQ_WIDTH'(win);
        next_recv_seq <= SEQ_WIDTH'(win);
      end
      // drop the head slot, move the rest down, refill the tail
      if (do_slide) begin
        for (int k = 0; k < MAX_WINDOW - 1; k++) begin
          if (CNT_W'(k + 1) < win) begin
            send_seq[k]   <= send_seq[k + 1];
            slot_acked[k] <= slot_acked[k + 1];
          end
        end
        for (int k = 0; k < MAX_WINDOW; k++) begin
          if (CNT_W'(k + 1) == win) begin
            send_seq[k]   <= SEQ_W'(send_m);
            slot_acked[k] <= 1'b0;
          end
        end
        next_send_seq <= send_inc;
      end
      if (emit_visit || do_restart) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      req_q <= req;
    end
    if (emit_visit) begin
      rsp.slot       <= SLOT_W'(cur);
      rsp.seq_number <= SEQ_NUM_W'(cur_seq);
      rsp.outcome    <= outcome;
      rsp.last       <= !more_after;
    end else if (do_restart) begin
      rsp.slot       <= '0;
      rsp.seq_number <= '0;
      rsp.outcome    <= OUT_RESTARTED;
      rsp.last       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_restart_form: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.outcome == OUT_RESTARTED) |->
      (rsp.last && rsp.slot == '0 && rsp.seq_number == '0))
    else $error("restart result malformed");

  a_head_ack_source: assert property (@(posedge clk) disable iff (rst)
    $rose(slot_acked[0]) |-> ($past(ctrl.op) == OP_VISIT || $past(ctrl.op) == OP_SLIDE))
    else $error("head slot acknowledged outside a round");
`endif

endmodule

`default_nettype wire

// File: hdl/selective_repeat_arq_window.sv
`default_nettype none

// Sender and receiver windows of a selective-repeat ARQ link. A command with
// func clear reloads both windows from sequence zero and answers with one
// restarted result. A command with func set runs one transmission round: one
// result per unacknowledged sender slot, in slot order, the final one marked
// by last, after which the sender window slides past its leading acknowledged
// slots and refills with fresh numbers. A round with every slot acknowledged
// gives no result. Control is a small microprogram stepping a shared slot
// datapath one slot per cycle while the result side does not stall. The
// next command is taken once the previous one has finished; its results may
// still sit in the output register. The user must write seq_bits only
// between commands; the block itself does not enforce this.
module selective_repeat_arq_window
  import srarq_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int SEQ_WIDTH  = DEF_SEQ_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration: seq_bits
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  // command transfer
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  // result transfer
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp
);

  ctrl_t ctrl;
  stat_t stat;

  // step counter and control store
  srarq_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // window state, slot datapath and output register
  srarq_dpath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_WIDTH  (SEQ_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req       (req),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // commands are taken only at the fetch step of the program
  assign req_stall = (ctrl.op != OP_FETCH);

endmodule

`default_nettype wire

// File: tb/selective_repeat_arq_window_tb.sv
`timescale 1ns / 100ps

module selective_repeat_arq_window_tb;
  import srarq_pkg::*;

  localparam int MAX_WINDOW   = DEF_MAX_WINDOW;
  localparam int SEQ_WIDTH    = DEF_SEQ_WIDTH;
  // cycles allowed after the last result before the block counts as idle
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 32;
  localparam int PRINT_CAP     = 60;

  // tracks both windows and holds the results still owed by the block
  class window_tracker;
    bit [CFG_W-1:0]     seq_bits;
    bit [SEQ_NUM_W-1:0] tx_seq [MAX_WINDOW];
    bit                 tx_acked [MAX_WINDOW];
    bit [SEQ_NUM_W-1:0] rx_wanted [MAX_WINDOW];
    bit [SEQ_NUM_W-1:0] tx_next;
    bit [SEQ_NUM_W-1:0] rx_next;
    rsp_t               due_reports[$];
    int                 mismatch_count;

    function new();
      seq_bits = CFG_W'(RESET_SEQ_BITS);
      mismatch_count = 0;
      reload();
    endfunction

    // out-of-range widths clamp to 1..SEQ_WIDTH
    function int unsigned eff_bits();
      int unsigned b;
      b = seq_bits;
      if (b < 1) b = 1;
      if (b > SEQ_WIDTH) b = SEQ_WIDTH;
      return b;
    endfunction

    function int unsigned win_size();
      int unsigned w;
      w = 1 << (eff_bits() - 1);
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      return w;
    endfunction

    function void reload();
      int unsigned m;
      m = (1 << eff_bits()) - 1;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        tx_seq[i]    = SEQ_NUM_W'(i);
        rx_wanted[i] = SEQ_NUM_W'(i);
        tx_acked[i]  = 1'b0;
      end
      tx_next = SEQ_NUM_W'(win_size() & m);
      rx_next = SEQ_NUM_W'(win_size() & m);
    endfunction

    function void set_seq_bits(bit [CFG_W-1:0] v);
      seq_bits = v;
    endfunction

    function void note_command(req_t c);
      int unsigned m, w, first, dst, before_cnt;
      bit fresh;
      rsp_t r;
      m = (1 << eff_bits()) - 1;
      w = win_size();
      if (c.func == FUNC_RESTART) begin
        reload();
        r.slot = '0;
        r.seq_number = '0;
        r.outcome = OUT_RESTARTED;
        r.last = 1'b1;
        due_reports.push_back(r);
        return;
      end
      before_cnt = due_reports.size();
      for (int i = 0; i < w; i++) begin
        if (tx_acked[i]) continue;
        if (c.frame_arrived_mask[i]) begin
          // receiver takes the frame only if its number is still wanted
          fresh = 1'b0;
          for (int j = 0; j < w; j++) begin
            if (!fresh && rx_wanted[j] == tx_seq[i]) begin
              rx_wanted[j] = SEQ_NUM_W'(rx_next & m);
              rx_next = SEQ_NUM_W'(((rx_next & m) + 1) & m);
              fresh = 1'b1;
            end
          end
          if (c.ack_arrived_mask[i]) begin
            tx_acked[i] = 1'b1;
            r.outcome = fresh ? OUT_NEW_ACKED : OUT_DUP_ACKED;
          end else begin
            r.outcome = fresh ? OUT_NEW_ACK_LOST : OUT_DUP_ACK_LOST;
          end
        end else begin
          r.outcome = c.frame_damaged_mask[i] ? OUT_DAMAGED_NAK : OUT_LOST;
        end
        r.slot = SLOT_W'(i);
        r.seq_number = tx_seq[i];
        r.last = 1'b0;
        due_reports.push_back(r);
      end
      if (due_reports.size() > before_cnt) begin
        r = due_reports.pop_back();
        r.last = 1'b1;
        due_reports.push_back(r);
      end
      // slide past leading acked slots, refill the tail
      first = w;
      for (int j = w - 1; j >= 0; j--)
        if (!tx_acked[j]) first = j;
      dst = 0;
      for (int k = first; k < w; k++) begin
        tx_seq[dst] = tx_seq[k];
        tx_acked[dst] = tx_acked[k];
        dst++;
      end
      for (int k = dst; k < w; k++) begin
        tx_seq[k] = SEQ_NUM_W'(tx_next & m);
        tx_next = SEQ_NUM_W'(((tx_next & m) + 1) & m);
        tx_acked[k] = 1'b0;
      end
    endfunction

    task report(string msg);
      if (mismatch_count < PRINT_CAP) $display("%0t: mismatch: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (due_reports.size() == 0) begin
        report($sformatf("unexpected result slot %0d seq %0d outcome %0d last %0d",
                         got.slot, got.seq_number, got.outcome, got.last));
        return;
      end
      want = due_reports.pop_front();
      if (got.slot != want.slot)
        report($sformatf("slot %0d, want %0d", got.slot, want.slot));
      if (got.seq_number != want.seq_number)
        report($sformatf("slot %0d seq_number %0d, want %0d",
                         want.slot, got.seq_number, want.seq_number));
      if (got.outcome != want.outcome)
        report($sformatf("slot %0d outcome %0d, want %0d",
                         want.slot, got.outcome, want.outcome));
      if (got.last != want.last)
        report($sformatf("slot %0d last %0d, want %0d", want.slot, got.last, want.last));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;

  window_tracker sb;
  int            cycle_count;
  // idling switches and the long receiver hold-off, set by the sequencer
  bit            tx_idle;
  bit            rx_idle;
  int            hold_left;

  selective_repeat_arq_window #(
    .MAX_WINDOW(MAX_WINDOW),
    .SEQ_WIDTH (SEQ_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // transfers are taken at the edge from pre-edge values; results are
  // checked before the command of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp);
      if (req_valid && !req_stall) sb.note_command(req);
    end
  end

  // result side: random stalls, plus the long hold-off when requested
  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
        if (rx_idle) begin
          r = $urandom_range(0, 99);
          // mostly short stalls, a few long ones
          if (r < 20) stall_left = $urandom_range(1, 3);
          else if (r < 23) stall_left = $urandom_range(5, 15);
          else if (r < 24) stall_left = $urandom_range(25, 40);
        end
      end
      @(posedge clk);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t make_cmd(logic f, logic [MASK_W-1:0] arrived,
                                    logic [MASK_W-1:0] damaged, logic [MASK_W-1:0] acks);
    req_t c;
    c.func = f;
    c.frame_arrived_mask = arrived;
    c.frame_damaged_mask = damaged;
    c.ack_arrived_mask = acks;
    return c;
  endfunction

  // mostly plausible rounds (frames and acks usually get through) so the
  // windows keep sliding; the rest are arbitrary masks, all-or-nothing rounds and restarts
  function automatic req_t random_cmd();
    logic [MASK_W-1:0] arrived, acks;
    int unsigned r;
    r = $urandom_range(0, 99);
    arrived = MASK_W'($urandom_range(0, 255));
    acks = MASK_W'($urandom_range(0, 255));
    if (r < 8) return make_cmd(FUNC_RESTART, arrived, MASK_W'($urandom_range(0, 255)), acks);
    if (r >= 38 && r < 90) begin
      for (int i = 0; i < MASK_W; i++) begin
        arrived[i] = ($urandom_range(0, 99) < 80);
        acks[i] = ($urandom_range(0, 99) < 80);
      end
    end else if (r >= 90) begin
      arrived = (r < 96) ? 8'hFF : 8'h00;
      acks = (r < 96) ? 8'hFF : acks;
    end
    return make_cmd(FUNC_ROUND, arrived, MASK_W'($urandom_range(0, 255)), acks);
  endfunction

  // offer one command; valid stays high across back-to-back transfers
  task automatic send_cmd(input req_t c);
    int unsigned gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= c;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_round(input logic [MASK_W-1:0] arrived,
                            input logic [MASK_W-1:0] damaged, input logic [MASK_W-1:0] acks);
    send_cmd(make_cmd(FUNC_ROUND, arrived, damaged, acks));
  endtask

  // stop offering, wait for every owed result, then let the block go quiet
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seq_bits(input logic [CFG_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_seq_bits(v);
  endtask

  initial begin
    logic [CFG_W-1:0] phase_bits [9];
    sb = new();
    cycle_count = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_left = 0;
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_valid <= 1'b0;
    req <= '0;
    phase_bits = '{3'd3, 3'd4, 3'd2, 3'd1, 3'd0, 3'd7, 3'd4, 3'd6, 3'd3};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // window of 4: every outcome but a duplicate with a lost ack, mask bits above the window ignored
    write_seq_bits(3'd3);
    send_round(8'h0F, 8'h00, 8'h0F);  // all new and acked, full slide
    send_round(8'h00, 8'hFF, 8'h00);  // all damaged
    send_round(8'h00, 8'h00, 8'hFF);  // all lost, acks without a frame ignored
    send_round(8'hFF, 8'h00, 8'h00);  // new, acks lost
    send_round(8'hFF, 8'h00, 8'hFF);  // resent frames are duplicates
    send_round(8'h0F, 8'h00, 8'h0A);  // acked slots behind an unacked head
    send_round(8'h05, 8'h02, 8'h05);
    send_cmd(make_cmd(FUNC_RESTART, 8'hFF, 8'hFF, 8'hFF));
    settle();

    // widest window
    write_seq_bits(3'd4);
    send_cmd(make_cmd(FUNC_RESTART, 8'h00, 8'h00, 8'h00));
    send_round(8'hFF, 8'h00, 8'hAA);
    send_round(8'hFF, 8'hFF, 8'h55);
    send_round(8'h80, 8'h7F, 8'h80);
    settle();

    // shrink without restart: stored numbers kept, fresh ones wrap mod 2
    write_seq_bits(3'd1);
    send_round(8'h01, 8'h00, 8'h01);
    send_round(8'h01, 8'h00, 8'h00);
    send_round(8'h00, 8'h01, 8'h00);
    settle();

    // zero width acts as one
    write_seq_bits(3'd0);
    send_round(8'hFF, 8'hFF, 8'hFF);
    send_cmd(make_cmd(FUNC_RESTART, 8'hFF, 8'h00, 8'hFF));
    send_round(8'h01, 8'h00, 8'h01);
    settle();

    // width above the maximum clamps to it
    write_seq_bits(3'd7);
    send_round(8'hFF, 8'h00, 8'hFF);
    send_round(8'h00, 8'h00, 8'h00);
    settle();
    write_seq_bits(3'd5);
    send_cmd(make_cmd(FUNC_RESTART, 8'h00, 8'h00, 8'h00));
    send_round(8'hFE, 8'h01, 8'hFE);

    // random phases over several widths, restart at the start only sometimes
    for (int p = 0; p < 9; p++) begin
      settle();
      write_seq_bits(phase_bits[p]);
      tx_idle = (p != 2);
      rx_idle = (p != 2);
      if (p == 4) begin
        // receiver holds off while commands keep coming back to back
        tx_idle = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 1)) send_cmd(make_cmd(FUNC_RESTART, 8'h00, 8'h00, 8'h00));
      repeat (PHASE_ITEMS) send_cmd(random_cmd());
    end

    settle();
    if (sb.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
